FILE: design/fsa_pkg.sv
// File sector allocator package: field widths, parameter defaults, status codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package fsa_pkg;

  localparam int MAP_SECTORS_DEF  = 256;
  localparam int DIR_SLOTS_DEF    = 16;
  localparam int SLOT_SECTORS_DEF = 20;

  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;
  localparam int SECTOR_W = 8;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_DIR_FULL  = 2'd1,
    STATUS_NO_SPACE  = 2'd2,
    STATUS_TOO_LARGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    FSA_CLEAR,
    FSA_IDLE,
    FSA_SCAN,
    FSA_DECIDE,
    FSA_ALLOC
  } state_e;

  typedef struct packed {
    logic clear;
    logic load;
    logic scan;
    logic emit_single;
    logic alloc_start;
    logic alloc_step;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic scan_done;
    logic go_alloc;
    logic out_free;
    logic alloc_done;
  } sts_t;

endpackage

FILE: design/fsa_if.sv
// Request and result channel interfaces of the file sector allocator.
// Depends on fsa_pkg for field widths.
interface fsa_req_if;
  logic                        valid;
  logic                        ready;
  logic [fsa_pkg::COUNT_W-1:0] sector_count;

  modport source (output valid, output sector_count, input ready);
  modport sink (input valid, input sector_count, output ready);
endinterface

interface fsa_res_if;
  logic                         valid;
  logic                         ready;
  logic [fsa_pkg::STATUS_W-1:0] status;
  logic [fsa_pkg::SLOT_W-1:0]   slot;
  logic [fsa_pkg::SECTOR_W-1:0] sector;
  logic                         sector_valid;
  logic                         last;

  modport source (output valid, output status, output slot, output sector,
                  output sector_valid, output last, input ready);
  modport sink (input valid, input status, input slot, input sector,
                input sector_valid, input last, output ready);
endinterface

FILE: design/fsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fsa_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 320
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/fsa_ctrl.sv
// Controller of the file sector allocator: sector map clearing after reset, request
// handshake and sequencing of the scan, decision and allocation phases. Depends on fsa_pkg.
module fsa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  fsa_pkg::sts_t sts_i,
  output fsa_pkg::cmd_t cmd_o
);

  fsa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fsa_pkg::FSA_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      fsa_pkg::FSA_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_done) begin
          state_d = fsa_pkg::FSA_IDLE;
        end
      end
      fsa_pkg::FSA_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = fsa_pkg::FSA_SCAN;
        end
      end
      fsa_pkg::FSA_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = fsa_pkg::FSA_DECIDE;
        end
      end
      fsa_pkg::FSA_DECIDE: begin
        if (sts_i.go_alloc) begin
          cmd_o.alloc_start = 1'b1;
          state_d           = fsa_pkg::FSA_ALLOC;
        end else if (sts_i.out_free) begin
          cmd_o.emit_single = 1'b1;
          state_d           = fsa_pkg::FSA_IDLE;
        end
      end
      fsa_pkg::FSA_ALLOC: begin
        cmd_o.alloc_step = 1'b1;
        if (sts_i.alloc_done) begin
          state_d = fsa_pkg::FSA_IDLE;
        end
      end
      default: begin
        state_d = fsa_pkg::FSA_IDLE;
      end
    endcase
  end

endmodule

FILE: design/fsa_datapath.sv
// Datapath of the file sector allocator: sector map RAM, slot map, scan counters,
// sector list RAM and the result register. Depends on fsa_pkg and fsa_ram.
module fsa_datapath #(
  parameter int MAP_SECTORS  = fsa_pkg::MAP_SECTORS_DEF,
  parameter int DIR_SLOTS    = fsa_pkg::DIR_SLOTS_DEF,
  parameter int SLOT_SECTORS = fsa_pkg::SLOT_SECTORS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [fsa_pkg::COUNT_W-1:0]   sector_count_i,
  input  fsa_pkg::cmd_t                 cmd_i,
  output fsa_pkg::sts_t                 sts_o,
  input  logic                          res_ready_i,
  output logic                          res_valid_o,
  output logic [fsa_pkg::STATUS_W-1:0]  res_status_o,
  output logic [fsa_pkg::SLOT_W-1:0]    res_slot_o,
  output logic [fsa_pkg::SECTOR_W-1:0]  res_sector_o,
  output logic                          res_sector_valid_o,
  output logic                          res_last_o
);

  localparam int SCAN_LEN   = (MAP_SECTORS > DIR_SLOTS) ? MAP_SECTORS : DIR_SLOTS;
  localparam int SCAN_W     = $clog2(SCAN_LEN);
  localparam int MAP_W      = $clog2(MAP_SECTORS);
  localparam int DIR_W      = $clog2(DIR_SLOTS);
  localparam int LIST_DEPTH = DIR_SLOTS * SLOT_SECTORS;
  localparam int LIST_W     = $clog2(LIST_DEPTH);
  localparam int CW         = fsa_pkg::COUNT_W;
  localparam logic [SCAN_W:0] MapLim  = (SCAN_W + 1)'(MAP_SECTORS);
  localparam logic [SCAN_W:0] DirLim  = (SCAN_W + 1)'(DIR_SLOTS);
  localparam logic [SCAN_W-1:0] ScanLast = SCAN_W'(SCAN_LEN - 1);
  localparam logic [SCAN_W-1:0] MapLast  = SCAN_W'(MAP_SECTORS - 1);
  localparam logic [CW:0] SlotLim = (CW + 1)'(SLOT_SECTORS);

  logic [DIR_SLOTS-1:0]   slot_used_q, slot_used_d;
  logic [CW-1:0]          need_q, need_d;
  logic [SCAN_W-1:0]      idx_q, idx_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   found_q, found_d;
  logic [DIR_W-1:0]       slot_q, slot_d;
  logic [CW-1:0]          n_q, n_d;

  logic                          res_valid_q, res_valid_d;
  logic [fsa_pkg::STATUS_W-1:0]  res_status_q, res_status_d;
  logic [fsa_pkg::SLOT_W-1:0]    res_slot_q, res_slot_d;
  logic [fsa_pkg::SECTOR_W-1:0]  res_sector_q, res_sector_d;
  logic                          res_sector_valid_q, res_sector_valid_d;
  logic                          res_last_q, res_last_d;

  logic                    idx_in_map, idx_in_dir, sec_free, slot_free;
  logic                    sector_used_rd;
  logic                    found_nx;
  logic [CW-1:0]           cnt_nx;
  fsa_pkg::status_e        verdict;
  logic                    out_free, alloc_last, alloc_emit;
  logic [DIR_W+fsa_pkg::SLOT_W-1:0]   slot_ext;
  logic [MAP_W+fsa_pkg::SECTOR_W-1:0] sector_ext;
  logic [LIST_W-1:0]       list_addr;

  assign idx_in_map = {1'b0, idx_q} < MapLim;
  assign idx_in_dir = {1'b0, idx_q} < DirLim;
  assign sec_free   = idx_in_map && !sector_used_rd;
  assign slot_free  = idx_in_dir && !slot_used_q[idx_q[DIR_W-1:0]];
  assign found_nx   = found_q || slot_free;
  assign cnt_nx     = (sec_free && (cnt_q != need_q)) ? cnt_q + CW'(1) : cnt_q;

  always_comb begin
    if (!found_q) begin
      verdict = fsa_pkg::STATUS_DIR_FULL;
    end else if (cnt_q != need_q) begin
      verdict = fsa_pkg::STATUS_NO_SPACE;
    end else if ({1'b0, need_q} > SlotLim) begin
      verdict = fsa_pkg::STATUS_TOO_LARGE;
    end else begin
      verdict = fsa_pkg::STATUS_OK;
    end
  end

  assign out_free   = !res_valid_q || res_ready_i;
  assign alloc_last = (n_q + CW'(1)) == need_q;
  assign alloc_emit = cmd_i.alloc_step && sec_free && out_free;
  assign slot_ext   = {{fsa_pkg::SLOT_W{1'b0}}, slot_q};
  assign sector_ext = {{fsa_pkg::SECTOR_W{1'b0}}, idx_q[MAP_W-1:0]};
  assign list_addr  = LIST_W'(int'(slot_q) * SLOT_SECTORS + int'(n_q));

  assign sts_o.clear_done = idx_q == MapLast;
  assign sts_o.scan_done  = (idx_q == ScanLast) || (found_nx && (cnt_nx == need_q));
  assign sts_o.go_alloc   = (verdict == fsa_pkg::STATUS_OK) && (need_q != '0);
  assign sts_o.out_free   = out_free;
  assign sts_o.alloc_done = alloc_emit && alloc_last;

  always_comb begin
    slot_used_d        = slot_used_q;
    need_d             = need_q;
    idx_d              = idx_q;
    cnt_d              = cnt_q;
    found_d            = found_q;
    slot_d             = slot_q;
    n_d                = n_q;
    res_valid_d        = res_valid_q && !res_ready_i;
    res_status_d       = res_status_q;
    res_slot_d         = res_slot_q;
    res_sector_d       = res_sector_q;
    res_sector_valid_d = res_sector_valid_q;
    res_last_d         = res_last_q;

    if (cmd_i.clear) begin
      idx_d = idx_q + SCAN_W'(1);
    end

    if (cmd_i.load) begin
      need_d  = sector_count_i;
      idx_d   = '0;
      cnt_d   = '0;
      found_d = 1'b0;
    end

    if (cmd_i.scan) begin
      cnt_d   = cnt_nx;
      found_d = found_nx;
      if (!found_q && slot_free) begin
        slot_d = idx_q[DIR_W-1:0];
      end
      if (!sts_o.scan_done) begin
        idx_d = idx_q + SCAN_W'(1);
      end
    end

    if (cmd_i.emit_single) begin
      res_valid_d        = 1'b1;
      res_status_d       = verdict;
      res_sector_d       = '0;
      res_sector_valid_d = 1'b0;
      res_last_d         = 1'b1;
      if (verdict == fsa_pkg::STATUS_OK) begin
        res_slot_d           = slot_ext[fsa_pkg::SLOT_W-1:0];
        slot_used_d[slot_q]  = 1'b1;
      end else begin
        res_slot_d = '0;
      end
    end

    if (cmd_i.alloc_start) begin
      idx_d               = '0;
      n_d                 = '0;
      slot_used_d[slot_q] = 1'b1;
    end

    if (cmd_i.alloc_step) begin
      if (!sec_free) begin
        idx_d = idx_q + SCAN_W'(1);
      end else if (out_free) begin
        idx_d              = idx_q + SCAN_W'(1);
        n_d                = n_q + CW'(1);
        res_valid_d        = 1'b1;
        res_status_d       = fsa_pkg::STATUS_OK;
        res_slot_d         = slot_ext[fsa_pkg::SLOT_W-1:0];
        res_sector_d       = sector_ext[fsa_pkg::SECTOR_W-1:0];
        res_sector_valid_d = 1'b1;
        res_last_d         = alloc_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_used_q   <= '0;
      found_q       <= 1'b0;
      res_valid_q   <= 1'b0;
      idx_q         <= '0;
      cnt_q         <= '0;
      n_q           <= '0;
    end else begin
      slot_used_q   <= slot_used_d;
      found_q       <= found_d;
      res_valid_q   <= res_valid_d;
      idx_q         <= idx_d;
      cnt_q         <= cnt_d;
      n_q           <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    need_q             <= need_d;
    slot_q             <= slot_d;
    res_status_q       <= res_status_d;
    res_slot_q         <= res_slot_d;
    res_sector_q       <= res_sector_d;
    res_sector_valid_q <= res_sector_valid_d;
    res_last_q         <= res_last_d;
  end

  fsa_ram #(
    .DATA_W (1),
    .DEPTH  (MAP_SECTORS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (alloc_emit || cmd_i.clear),
    .waddr_i (idx_q[MAP_W-1:0]),
    .wdata_i (alloc_emit),
    .raddr_i (idx_d[MAP_W-1:0]),
    .rdata_o (sector_used_rd)
  );

  fsa_ram #(
    .DATA_W (fsa_pkg::SECTOR_W),
    .DEPTH  (LIST_DEPTH)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (alloc_emit),
    .waddr_i (list_addr),
    .wdata_i (sector_ext[fsa_pkg::SECTOR_W-1:0]),
    .raddr_i ('0),
    .rdata_o ()
  );

  assign res_valid_o        = res_valid_q;
  assign res_status_o       = res_status_q;
  assign res_slot_o         = res_slot_q;
  assign res_sector_o       = res_sector_q;
  assign res_sector_valid_o = res_sector_valid_q;
  assign res_last_o         = res_last_q;

`ifndef SYNTH
  a_alloc_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc_start |-> found_q && (cnt_q == need_q) && (need_q != '0))
    else $error("allocation started without a slot or enough free sectors");

  a_alloc_in_map : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc_step |-> idx_in_map)
    else $error("allocation scan ran past the sector map");

  a_alloc_slot_claimed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc_step |-> slot_used_q[slot_q])
    else $error("sectors allocated to an unclaimed slot");

  a_emit_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    alloc_emit |=> (n_q == $past(n_q) + CW'(1)) && res_valid_q)
    else $error("allocated sector not counted or not presented");
`endif

endmodule

FILE: design/file_sector_allocator_top.sv
// File sector allocator: one request at a time, first free slot, first free sectors.
// Steps: the request is accepted, a scan walks up to max(MAP_SECTORS, DIR_SLOTS) entries
// of the sector and slot maps, a decision follows, then the map is walked again entry by
// entry up to the last allocated sector. A new request is taken only when the last is done;
// the walk halts at a free sector and the single result waits while the result channel stalls.
// Reset: slot map clears at once, sector map by a pass over every entry; list RAM uncleared.
module file_sector_allocator_top #(
  parameter int MAP_SECTORS  = fsa_pkg::MAP_SECTORS_DEF,
  parameter int DIR_SLOTS    = fsa_pkg::DIR_SLOTS_DEF,
  parameter int SLOT_SECTORS = fsa_pkg::SLOT_SECTORS_DEF
) (
  input logic      clk_i,
  input logic      rst_ni,
  fsa_req_if.sink  req,
  fsa_res_if.source res
);

  fsa_pkg::cmd_t cmd;
  fsa_pkg::sts_t sts;

  fsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fsa_datapath #(
    .MAP_SECTORS  (MAP_SECTORS),
    .DIR_SLOTS    (DIR_SLOTS),
    .SLOT_SECTORS (SLOT_SECTORS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .sector_count_i     (req.sector_count),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .res_ready_i        (res.ready),
    .res_valid_o        (res.valid),
    .res_status_o       (res.status),
    .res_slot_o         (res.slot),
    .res_sector_o       (res.sector),
    .res_sector_valid_o (res.sector_valid),
    .res_last_o         (res.last)
  );

endmodule
